FILE: design/bsrq_pkg.sv
package bsrq_pkg;

	// Array geometry. Both sizes are powers of two.
	localparam int DEPTH      = 1024;
	localparam int BLOCK_SIZE = 32;
	localparam int NUM_BLOCKS = DEPTH / BLOCK_SIZE;

	// Widths of data, element addresses, block addresses and the in-block offset.
	localparam int DATA_W  = 32;
	localparam int FIELD_W = 10;
	localparam int AW      = $clog2(DEPTH);
	localparam int BSW     = $clog2(BLOCK_SIZE);
	localparam int BW      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

	// Position width: holds any field value and any position up to DEPTH-1+BLOCK_SIZE.
	localparam int PW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;

	localparam logic [PW-1:0] POS_LIMIT  = PW'(DEPTH);
	localparam logic [PW-1:0] POS_LAST   = PW'(DEPTH - 1);
	localparam logic [PW-1:0] POS_BLOCK  = PW'(BLOCK_SIZE);
	localparam logic [PW-1:0] POS_BLK_M1 = PW'(BLOCK_SIZE - 1);
	localparam logic [PW-1:0] POS_ONE    = PW'(1);
	localparam logic [AW-1:0] CLR_LAST   = AW'(DEPTH - 1);

	// Operation codes carried on the op port.
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// One step of the range walk.
	typedef struct packed {
		logic          active;
		logic          use_block;
		logic [AW-1:0] elem_addr;
		logic [BW-1:0] blk_addr;
		logic [PW-1:0] pos_next;
	} step_t;

endpackage

FILE: design/bsrq_ram.sv
module bsrq_ram #(
	parameter int WIDTH = 32,
	parameter int WORDS = 1024,
	parameter int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [WORDS];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/bsrq_step.sv
module bsrq_step (
	input  logic [bsrq_pkg::PW-1:0] pos,
	input  logic [bsrq_pkg::PW-1:0] hi,
	output bsrq_pkg::step_t         step
);
	import bsrq_pkg::*;

	logic aligned;
	logic fits;

	// A whole block is taken when the walk sits on a block start and the block ends in range.
	assign aligned = (pos[BSW-1:0] == '0);
	assign fits    = ((pos + POS_BLK_M1) <= hi);

	always_comb begin
		step.active    = (pos <= hi);
		step.use_block = aligned && fits;
		step.elem_addr = pos[AW-1:0];
		step.blk_addr  = BW'(pos >> BSW);
		step.pos_next  = pos + (step.use_block ? POS_BLOCK : POS_ONE);
	end

endmodule

FILE: design/block_sum_range_query.sv
// Channel   Ports                                  Handshake
// command   op, index, delta, left, right          start && !busy
// result    range_sum                              done, one cycle, no stall
//
// After reset a clearing pass zeroes both stores, one element a cycle, over all DEPTH elements;
// busy stays high meanwhile. An add keeps busy high while it reads, then writes back.
// A query keeps busy high while it walks the range, k being the number of reads of the walk,
// at most 2*(BLOCK_SIZE-1) + DEPTH/BLOCK_SIZE; an empty range makes no reads.
// Each store has one memory read port, so each step of the walk reads one word.
// done rises in the cycle busy falls, and the receiver cannot hold a result off.
module block_sum_range_query (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              op,
	input  logic [bsrq_pkg::FIELD_W-1:0]      index,
	input  logic signed [bsrq_pkg::DATA_W-1:0] delta,
	input  logic [bsrq_pkg::FIELD_W-1:0]      left,
	input  logic [bsrq_pkg::FIELD_W-1:0]      right,
	output logic                              done,
	output logic signed [bsrq_pkg::DATA_W-1:0] range_sum
);
	import bsrq_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_ADD_RD = 5'b00100,
		S_ADD_WR = 5'b01000,
		S_QUERY  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     clr_q;
	logic [AW-1:0]     idx_q;
	logic [DATA_W-1:0] delta_q;
	logic [PW-1:0]     pos_q;
	logic [PW-1:0]     hi_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] range_sum_q;
	logic              done_q;
	logic              pend_s1;
	logic              blk_s1;

	logic              accept;
	logic [PW-1:0]     index_ext;
	logic [PW-1:0]     right_ext;
	step_t             step;

	logic              elem_we;
	logic [AW-1:0]     elem_waddr;
	logic [DATA_W-1:0] elem_wdata;
	logic [AW-1:0]     elem_raddr;
	logic [DATA_W-1:0] elem_rdata;
	logic              blk_we;
	logic [BW-1:0]     blk_waddr;
	logic [DATA_W-1:0] blk_wdata;
	logic [BW-1:0]     blk_raddr;
	logic [DATA_W-1:0] blk_rdata;
	logic [BW-1:0]     idx_blk;
	logic [BW-1:0]     clr_blk;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign index_ext = PW'(index);
	assign right_ext = PW'(right);
	assign done      = done_q;
	assign range_sum = $signed(range_sum_q);
	assign idx_blk   = BW'(idx_q >> BSW);
	assign clr_blk   = BW'(clr_q >> BSW);

	// Next step of the range walk.
	bsrq_step u_step (
		.pos  (pos_q),
		.hi   (hi_q),
		.step (step)
	);

	// Memory ports: the clearing pass writes zero, an add writes the updated word back.
	always_comb begin
		elem_we    = (state_q == S_CLEAR) || (state_q == S_ADD_WR);
		elem_waddr = (state_q == S_CLEAR) ? clr_q : idx_q;
		elem_wdata = (state_q == S_CLEAR) ? '0 : elem_rdata + delta_q;
		elem_raddr = (state_q == S_QUERY) ? step.elem_addr : idx_q;
		blk_we     = elem_we;
		blk_waddr  = (state_q == S_CLEAR) ? clr_blk : idx_blk;
		blk_wdata  = (state_q == S_CLEAR) ? '0 : blk_rdata + delta_q;
		blk_raddr  = (state_q == S_QUERY) ? step.blk_addr : idx_blk;
	end

	bsrq_ram #(.WIDTH(DATA_W), .WORDS(DEPTH)) u_elem_ram (
		.clk   (clk),
		.we    (elem_we),
		.waddr (elem_waddr),
		.wdata (elem_wdata),
		.raddr (elem_raddr),
		.rdata (elem_rdata)
	);

	bsrq_ram #(.WIDTH(DATA_W), .WORDS(NUM_BLOCKS)) u_blk_ram (
		.clk   (clk),
		.we    (blk_we),
		.waddr (blk_waddr),
		.wdata (blk_wdata),
		.raddr (blk_raddr),
		.rdata (blk_rdata)
	);

	// Sequencer: clearing pass, add read-modify-write, query walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			// The strobe is registered from the last cycle of a query walk.
			done_q <= (state_q == S_QUERY) && !step.active && !pend_s1;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						if (op != OP_ADD) begin
							state_q <= S_QUERY;
						end else if (index_ext < POS_LIMIT) begin
							state_q <= S_ADD_RD;
						end
					end
				end
				S_ADD_RD: begin
					state_q <= S_ADD_WR;
				end
				S_ADD_WR: begin
					state_q <= S_IDLE;
				end
				S_QUERY: begin
					pend_s1 <= step.active;
					if (!step.active && !pend_s1) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: the latched word, the walk position and the running sum.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q   <= index_ext[AW-1:0];
			delta_q <= delta;
			pos_q   <= PW'(left);
			hi_q    <= (right_ext >= POS_LIMIT) ? POS_LAST : right_ext;
			acc_q   <= '0;
		end else if (state_q == S_QUERY) begin
			if (step.active) begin
				pos_q  <= step.pos_next;
				blk_s1 <= step.use_block;
			end
			if (pend_s1) begin
				acc_q <= acc_q + (blk_s1 ? blk_rdata : elem_rdata);
			end
			if (!step.active && !pend_s1) begin
				range_sum_q <= acc_q;
			end
		end
	end

`ifndef SYNTHESIS
	// A result only appears once the block has gone back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// An accepted add never gives a result in the following cycle.
	a_add_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_ADD) |=> !done)
		else $error("add produced a result");

	// A read is in flight only during a query walk.
	a_pend_query: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == S_QUERY))
		else $error("pending read outside a query");
`endif

endmodule

FILE: tb/block_sum_range_query_tb.sv
module block_sum_range_query_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsrq_pkg::*;

	localparam int ITEMS_PER_PHASE = 580;
	localparam int DRAIN_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 120;
	localparam int MAX_REPORTS     = 10;

	// Mirror of the element array and block sums, plus the sums still owed by the block.
	class range_sum_board;
		logic [DATA_W-1:0] elems [DEPTH];
		logic [DATA_W-1:0] blocks [NUM_BLOCKS];
		logic [DATA_W-1:0] expected_sums [$];
		int errors;
		int reports;

		function new();
			foreach (elems[i]) elems[i] = '0;
			foreach (blocks[i]) blocks[i] = '0;
			errors = 0;
			reports = 0;
		endfunction

		// Walks the range the way the block does: whole blocks where they fit, single
		// elements at the ragged ends.
		function logic [DATA_W-1:0] walk_sum(int lo, int hi);
			logic [DATA_W-1:0] acc;
			int pos;
			acc = '0;
			if (lo >= DEPTH || lo > hi)
				return '0;
			if (hi >= DEPTH)
				hi = DEPTH - 1;
			pos = lo;
			while (pos <= hi) begin
				if (pos % BLOCK_SIZE == 0 && pos + BLOCK_SIZE - 1 <= hi) begin
					acc += blocks[pos / BLOCK_SIZE];
					pos += BLOCK_SIZE;
				end else begin
					acc += elems[pos];
					pos++;
				end
			end
			return acc;
		endfunction

		// Called for every accepted command word.
		function void note_word(logic op_i, logic [FIELD_W-1:0] index_i,
				logic [DATA_W-1:0] delta_i, logic [FIELD_W-1:0] left_i,
				logic [FIELD_W-1:0] right_i);
			if (op_i == OP_ADD) begin
				if (int'(index_i) < DEPTH) begin
					elems[index_i] += delta_i;
					blocks[int'(index_i) / BLOCK_SIZE] += delta_i;
				end
			end else begin
				expected_sums.insert(expected_sums.size(),
					walk_sum(int'(left_i), int'(right_i)));
			end
		endfunction

		function void report(string what, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
			errors++;
			if (reports < MAX_REPORTS) begin
				reports++;
				$display("MISMATCH %s: expected %0d (0x%08h) got %0d (0x%08h)", what,
					$signed(exp_v), exp_v, $signed(act_v), act_v);
			end
		endfunction

		// Called for every result word seen on the done strobe.
		function void check_sum(logic [DATA_W-1:0] actual);
			logic [DATA_W-1:0] exp_v;
			if (expected_sums.size() == 0) begin
				report("range_sum with no query outstanding", 'x, actual);
				return;
			end
			exp_v = expected_sums.pop_front();
			if (actual !== exp_v)
				report("range_sum", exp_v, actual);
		endfunction

		function int pending();
			return expected_sums.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic op = OP_ADD;
	logic [FIELD_W-1:0] index = '0;
	logic signed [DATA_W-1:0] delta = '0;
	logic [FIELD_W-1:0] left = '0;
	logic [FIELD_W-1:0] right = '0;
	logic busy;
	logic done;
	logic signed [DATA_W-1:0] range_sum;

	range_sum_board sb = new();
	int idle_pct = 0;

	block_sum_range_query u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.index     (index),
		.delta     (delta),
		.left      (left),
		.right     (right),
		.done      (done),
		.range_sum (range_sum)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result words are taken at the rising edge that ends the strobe cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_sum(range_sum);
	end

	// Presents one command word from a falling edge and holds it until accepted.
	// Returns at the falling edge after acceptance with start still high.
	task automatic send_word(logic op_i, logic [FIELD_W-1:0] index_i,
			logic [DATA_W-1:0] delta_i, logic [FIELD_W-1:0] left_i,
			logic [FIELD_W-1:0] right_i);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		op    <= op_i;
		index <= index_i;
		delta <= delta_i;
		left  <= left_i;
		right <= right_i;
		do
			@(posedge clk);
		while (busy);
		sb.note_word(op_i, index_i, delta_i, left_i, right_i);
		@(negedge clk);
	endtask

	task automatic add_word(int index_i, logic [DATA_W-1:0] delta_i);
		send_word(OP_ADD, FIELD_W'(index_i), delta_i, FIELD_W'($urandom), FIELD_W'($urandom));
	endtask

	task automatic query_word(int left_i, int right_i);
		send_word(OP_QUERY, FIELD_W'($urandom), $urandom, FIELD_W'(left_i), FIELD_W'(right_i));
	endtask

	// One random word: adds with mixed delta sizes, queries of several range shapes.
	task automatic random_word();
		logic [DATA_W-1:0] d;
		int l;
		int r;
		int b0;
		int b1;
		int pick;
		int shape;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			shape = $urandom_range(0, 99);
			if (shape < 60)
				d = $urandom;
			else if (shape < 85)
				d = DATA_W'($signed($urandom_range(0, 200)) - 100);
			else begin
				case ($urandom_range(0, 3))
					0: d = 32'h7FFF_FFFF;
					1: d = 32'h8000_0000;
					2: d = 32'hFFFF_FFFF;
					default: d = '0;
				endcase
			end
			add_word(int'($urandom_range(0, DEPTH - 1)), d);
		end else begin
			l = $urandom_range(0, DEPTH - 1);
			r = $urandom_range(0, DEPTH - 1);
			shape = $urandom_range(0, 99);
			if (shape < 60) begin
				if (l > r) begin
					b0 = l;
					l = r;
					r = b0;
				end
			end else if (shape < 75) begin
				// Range made of whole blocks only.
				b0 = $urandom_range(0, NUM_BLOCKS - 1);
				b1 = $urandom_range(b0, NUM_BLOCKS - 1);
				l = b0 * BLOCK_SIZE;
				r = (b1 + 1) * BLOCK_SIZE - 1;
			end else if (shape < 90) begin
				r = l + $urandom_range(0, BLOCK_SIZE + 8);
				if (r > DEPTH - 1)
					r = DEPTH - 1;
			end
			query_word(l, r);
		end
	endtask

	initial begin
		int waited;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words: cleared store, extreme deltas with wrap, block edges, empty ranges.
		idle_pct = 0;
		query_word(0, DEPTH - 1);
		add_word(0, 32'h7FFF_FFFF);
		add_word(0, 32'h7FFF_FFFF);
		add_word(DEPTH - 1, 32'h8000_0000);
		add_word(BLOCK_SIZE - 1, 32'hFFFF_FFFF);
		add_word(BLOCK_SIZE, 32'd5);
		add_word(511, 32'd1234);
		add_word(1000, -32'sd7);
		query_word(0, DEPTH - 1);
		query_word(0, 0);
		query_word(DEPTH - 1, DEPTH - 1);
		query_word(BLOCK_SIZE - 1, BLOCK_SIZE);
		query_word(BLOCK_SIZE, 2 * BLOCK_SIZE - 1);
		query_word(0, BLOCK_SIZE - 1);
		query_word(1, 2 * BLOCK_SIZE - 2);
		query_word(5, 3);
		query_word(DEPTH - 1, 0);
		query_word(DEPTH - BLOCK_SIZE, DEPTH - 1);
		query_word(BLOCK_SIZE + 1, DEPTH - 2);
		query_word(0, DEPTH - 2);
		query_word(1, DEPTH - 1);

		// Random words, sender idling lightly, then heavily, then not at all.
		idle_pct = 20;
		repeat (ITEMS_PER_PHASE) random_word();
		idle_pct = 51;
		repeat (ITEMS_PER_PHASE) random_word();
		idle_pct = 0;
		repeat (ITEMS_PER_PHASE) random_word();
		start <= 1'b0;

		// Let outstanding queries finish, then give the block time for any stray strobe.
		waited = 0;
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0d queries never answered", sb.pending());
			sb.errors += sb.pending();
		end

		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#40_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
